// ===== hdl/wes_pkg.sv =====
// ----------------------------------------------------------------------------
// Wheel encoder speed package
// Field widths, register indexes, reset values and arithmetic constants that
// are shared by the interfaces, the speed block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package wes_pkg;

  localparam int CountW   = 32;
  localparam int TimeW    = 64;
  localparam int SpeedW   = 24;
  localparam int DirW     = 2;
  localparam int RadiusW  = 20;
  localparam int PprW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int CfgWheels = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDirW0    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDirW1    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRadiusW0 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRadiusW1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPprW0    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPprW1    = 3'd5;

  // Register reset values.
  localparam logic [DirW-1:0]    DirReset    = 2'd1;
  localparam logic [RadiusW-1:0] RadiusReset = 20'd32500;
  localparam logic [PprW-1:0]    PprReset    = 16'd1320;

  // Speed scale: 2*pi approximated as 411775/65536, times 1000 for mm.
  localparam int                 SpeedKW   = 29;
  localparam logic [SpeedKW-1:0] SpeedK    = 29'd411775000;
  localparam int                 ScaleShift = 16;
  // Speed magnitude saturates at 2^23 - 1.
  localparam int                 MagW      = 23;
  localparam logic [MagW-1:0]    SpeedMax  = 23'd8388607;

  // Product widths of the two serial multiplies.
  localparam int ProdAW = CountW + RadiusW - 1;  // mag * radius
  localparam int ProdNW = ProdAW + SpeedKW;      // a * SpeedK

  typedef logic signed [CountW-1:0] count_t;
  typedef logic [TimeW-1:0]         time_t;
  typedef logic signed [SpeedW-1:0] speed_t;

endpackage

`default_nettype wire

// ===== hdl/wes_sample_if.sv =====
// ----------------------------------------------------------------------------
// Wheel encoder sample channel
// Valid/ready channel that carries one encoder sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wes_sample_if;
  import wes_pkg::*;

  logic   valid;
  logic   ready;
  logic   wheel_select;
  count_t raw_count;
  time_t  sample_time_us;

  modport source (output valid, wheel_select, raw_count, sample_time_us, input ready);
  modport sink   (input valid, wheel_select, raw_count, sample_time_us, output ready);
endinterface

`default_nettype wire

// ===== hdl/wes_result_if.sv =====
// ----------------------------------------------------------------------------
// Wheel encoder result channel
// Valid/ready channel that carries one speed result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wes_result_if;
  import wes_pkg::*;

  logic   valid;
  logic   ready;
  logic   sample_status;
  logic   wheel_echo;
  count_t count_echo;
  time_t  time_echo_us;
  speed_t speed_mmps;

  modport source (output valid, sample_status, wheel_echo, count_echo, time_echo_us,
                  speed_mmps, input ready);
  modport sink   (input valid, sample_status, wheel_echo, count_echo, time_echo_us,
                  speed_mmps, output ready);
endinterface

`default_nettype wire

// ===== hdl/wheel_encoder_speed.sv =====
// ----------------------------------------------------------------------------
// Wheel encoder speed estimator
// Turns wrapping encoder counts and microsecond timestamps into wheel speed.
// ----------------------------------------------------------------------------
// One sample transaction produces exactly one result transaction. The first
// sample of a wheel sets its baseline and reports speed 0; a sample whose
// timestamp is not after the wheel's last one is rejected (status 1, speed 0,
// state untouched). Otherwise the wrapped count delta is scaled to mm/s as
// delta * radius_um * 411775000 / (65536 * pulses_rev * dt_us), truncated
// toward zero, saturated at +-8388607 and signed by the wheel's direction.
// The block works on one sample at a time. A sample that needs the full
// calculation passes from acceptance to a loaded result register through a
// bit-serial count-by-radius multiply, a bit-serial multiply by the scale
// constant, a divide by pulses per revolution (two quotient bits a cycle), a
// saturation check and a divide by the time delta, which a saturated result
// skips. Samples that give speed 0 (first sample, rejection, zero direction,
// radius, pulses per revolution or count delta) skip the arithmetic and go
// straight from acceptance to the result register. The result register holds
// its transaction while the consumer stalls, so the next sample is accepted
// and worked on meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_encoder_speed #(
  parameter int NUM_WHEELS = 2
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  wes_sample_if.sink                 sample_i,
  wes_result_if.source               result_o,
  input  wire                        cfg_we_i,
  input  wire [wes_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [wes_pkg::CfgDataW-1:0] cfg_data_i
);
  import wes_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMulR = 3'd1;  // mag * radius, one radius bit a cycle
  localparam logic [2:0] StMulK = 3'd2;  // a * SpeedK, one constant bit a cycle
  localparam logic [2:0] StDivP = 3'd3;  // divide by pulses per revolution
  localparam logic [2:0] StChk  = 3'd4;  // saturation check before time divide
  localparam logic [2:0] StDivT = 3'd5;  // divide by time delta
  localparam logic [2:0] StFin  = 3'd6;  // wait for a free result register

  localparam int QuoHiW = TimeW - MagW;

  // Configuration registers.
  logic [DirW-1:0]    dir_q    [CfgWheels];
  logic [RadiusW-1:0] radius_q [CfgWheels];
  logic [PprW-1:0]    ppr_q    [CfgWheels];

  // Per-wheel baseline.
  count_t last_cnt_q  [NUM_WHEELS];
  time_t  last_time_q [NUM_WHEELS];
  logic   base_q      [NUM_WHEELS];

  // Sequencer and datapath registers.
  logic [2:0]         state_q, state_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               wheel_q, status_q, neg_q;
  count_t             count_q;
  time_t              time_q;
  logic [CountW-1:0]  mag_q;
  time_t              dt_q;
  logic [PprW-1:0]    pdiv_q;
  logic [ProdAW+1:0]  prod_a_q, prod_a_d;
  logic [ProdNW:0]    prod_n_q, prod_n_d;
  logic [TimeW-1:0]   quo_q, quo_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [MagW-1:0]    mres_q, mres_d;

  // Result register.
  logic   out_valid_q;
  logic   out_status_q, out_wheel_q;
  count_t out_count_q;
  time_t  out_time_q;
  speed_t out_speed_q;

  // --------------------------------------------------------------------------
  // Accept-cycle evaluation: baseline lookup, reject test, delta and sign.
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic              in_range, sel_base, reject, zero_path, neg_raw;
  count_t            sel_cnt;
  time_t             sel_time;
  logic [CountW-1:0] diff, mag;
  logic [DirW-1:0]   sel_dir;
  logic [RadiusW-1:0] sel_rad;
  logic [PprW-1:0]   sel_ppr;

  assign in_acc = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == StIdle);

  always_comb begin
    in_range = 1'b0;
    sel_base = 1'b0;
    sel_cnt  = '0;
    sel_time = '0;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (sample_i.wheel_select == 1'(w)) begin
        in_range = 1'b1;
        sel_base = base_q[w];
        sel_cnt  = last_cnt_q[w];
        sel_time = last_time_q[w];
      end
    end
  end

  assign sel_dir  = dir_q[sample_i.wheel_select];
  assign sel_rad  = radius_q[sample_i.wheel_select];
  assign sel_ppr  = ppr_q[sample_i.wheel_select];
  assign reject   = !in_range || (sel_base && (sample_i.sample_time_us <= sel_time));
  assign diff     = sample_i.raw_count - sel_cnt;
  assign neg_raw  = diff[CountW-1];
  // The most negative delta negates to itself, which is the right magnitude.
  assign mag      = neg_raw ? (~diff + 1'b1) : diff;
  assign zero_path = reject || !sel_base || (sel_dir == '0) || (sel_rad == '0)
                  || (sel_ppr == '0) || (mag == '0);

  // --------------------------------------------------------------------------
  // Serial arithmetic steps.
  // --------------------------------------------------------------------------
  logic [CountW:0]    sum_a;
  logic [ProdAW:0]    sum_n;
  logic [ProdAW+1:0]  prod_a_step;
  logic [ProdNW:0]    prod_n_step;
  logic [PprW:0]      pr1, pr2;
  logic [PprW-1:0]    pr1s, pr2s;
  logic               pge1, pge2;
  logic [TimeW:0]     tr;
  logic               tge;
  logic [TimeW-1:0]   trs;
  logic               sat;

  // Product shifts right; the multiplier bit leaves at the bottom.
  assign sum_a = prod_a_q[ProdAW+1:RadiusW] + (prod_a_q[0] ? {1'b0, mag_q} : '0);
  assign prod_a_step = {1'b0, sum_a, prod_a_q[RadiusW-1:1]};

  assign sum_n = prod_n_q[ProdNW:SpeedKW]
               + (prod_n_q[0] ? {1'b0, prod_a_q[ProdAW-1:0]} : '0);
  assign prod_n_step = {1'b0, sum_n, prod_n_q[SpeedKW-1:1]};

  // Two restoring steps per cycle against the 16-bit divisor.
  assign pr1  = {rem_q[PprW-1:0], quo_q[TimeW-1]};
  assign pge1 = (pr1 >= {1'b0, pdiv_q});
  assign pr1s = pge1 ? PprW'(pr1 - {1'b0, pdiv_q}) : pr1[PprW-1:0];
  assign pr2  = {pr1s, quo_q[TimeW-2]};
  assign pge2 = (pr2 >= {1'b0, pdiv_q});
  assign pr2s = pge2 ? PprW'(pr2 - {1'b0, pdiv_q}) : pr2[PprW-1:0];

  // One restoring step per cycle against the time delta.
  assign tr  = {rem_q, quo_q[TimeW-1]};
  assign tge = (tr >= {1'b0, dt_q});
  assign trs = tge ? TimeW'(tr - {1'b0, dt_q}) : tr[TimeW-1:0];

  // The quotient fits 23 bits exactly when the dividend's upper bits are
  // below the divisor.
  assign sat = ({{MagW{1'b0}}, quo_q[TimeW-1:MagW]} >= dt_q);

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state_q == StFin) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    prod_a_d = prod_a_q;
    prod_n_d = prod_n_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    mres_d   = mres_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          mres_d   = '0;
          prod_a_d = {{(ProdAW+2-RadiusW){1'b0}}, sel_rad};
          cnt_d    = 5'(RadiusW - 1);
          state_d  = zero_path ? StFin : StMulR;
        end
      end
      StMulR: begin
        prod_a_d = prod_a_step;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          prod_n_d = {{(ProdNW+1-SpeedKW){1'b0}}, SpeedK};
          cnt_d    = 5'(SpeedKW - 1);
          state_d  = StMulK;
        end
      end
      StMulK: begin
        prod_n_d = prod_n_step;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          quo_d   = prod_n_step[ProdNW-1:ScaleShift];
          rem_d   = '0;
          cnt_d   = 5'(TimeW / 2 - 1);
          state_d = StDivP;
        end
      end
      StDivP: begin
        quo_d = {quo_q[TimeW-3:0], pge1, pge2};
        rem_d = {{(TimeW-PprW){1'b0}}, pr2s};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StChk;
        end
      end
      StChk: begin
        if (sat) begin
          mres_d  = SpeedMax;
          state_d = StFin;
        end else begin
          rem_d   = {{MagW{1'b0}}, quo_q[TimeW-1:MagW]};
          quo_d   = {quo_q[MagW-1:0], {QuoHiW{1'b0}}};
          cnt_d   = 5'(MagW - 1);
          state_d = StDivT;
        end
      end
      StDivT: begin
        quo_d = {quo_q[TimeW-2:0], tge};
        rem_d = trs;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          mres_d  = quo_d[MagW-1:0];
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    prod_a_q <= prod_a_d;
    prod_n_q <= prod_n_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    mres_q   <= mres_d;
    if (in_acc) begin
      wheel_q  <= sample_i.wheel_select;
      count_q  <= sample_i.raw_count;
      time_q   <= sample_i.sample_time_us;
      status_q <= reject;
      neg_q    <= neg_raw ^ sel_dir[DirW-1];
      mag_q    <= mag;
      dt_q     <= sample_i.sample_time_us - sel_time;
      pdiv_q   <= sel_ppr;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_wheel_q  <= wheel_q;
      out_count_q  <= count_q;
      out_time_q   <= time_q;
      out_speed_q  <= neg_q ? -speed_t'({1'b0, mres_q}) : speed_t'({1'b0, mres_q});
    end
  end

  // --------------------------------------------------------------------------
  // Baseline update on every accepted, non-rejected sample.
  // --------------------------------------------------------------------------
  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
    logic upd;
    assign upd = in_acc && !reject && (sample_i.wheel_select == 1'(w));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        base_q[w] <= 1'b0;
      end else if (upd) begin
        base_q[w] <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (upd) begin
        last_cnt_q[w]  <= sample_i.raw_count;
        last_time_q[w] <= sample_i.sample_time_us;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes; unknown indexes are ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < CfgWheels; w++) begin
        dir_q[w]    <= DirReset;
        radius_q[w] <= RadiusReset;
        ppr_q[w]    <= PprReset;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDirW0:    dir_q[0]    <= cfg_data_i[DirW-1:0];
        RegDirW1:    dir_q[1]    <= cfg_data_i[DirW-1:0];
        RegRadiusW0: radius_q[0] <= cfg_data_i[RadiusW-1:0];
        RegRadiusW1: radius_q[1] <= cfg_data_i[RadiusW-1:0];
        RegPprW0:    ppr_q[0]    <= cfg_data_i[PprW-1:0];
        RegPprW1:    ppr_q[1]    <= cfg_data_i[PprW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result channel.
  assign result_o.valid         = out_valid_q;
  assign result_o.sample_status = out_status_q;
  assign result_o.wheel_echo    = out_wheel_q;
  assign result_o.count_echo    = out_count_q;
  assign result_o.time_echo_us  = out_time_q;
  assign result_o.speed_mmps    = out_speed_q;

endmodule

`default_nettype wire

// ===== hdl/wes_checker.sv =====
// ----------------------------------------------------------------------------
// Wheel encoder speed checker
// Port-level assertions on the speed block, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module wes_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_i,
  input wire                          out_valid_i,
  input wire                          out_ready_i,
  input wire                          out_status_i,
  input wire [wes_pkg::SpeedW-1:0]    out_speed_i
);
  import wes_pkg::*;

  // A held result keeps its speed and status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_speed_i)
                                    && $stable(out_status_i))
    else $error("result changed while stalled");

  // Only one sample is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample accepted while one is in work");

  // A rejected sample reports zero speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_speed_i == '0)
    else $error("rejected sample with nonzero speed");

  // Saturation is symmetric: the most negative code never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_speed_i != {1'b1, {(SpeedW-1){1'b0}}})
    else $error("speed outside saturation range");

endmodule

bind wheel_encoder_speed wes_checker u_wes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.sample_status),
  .out_speed_i  (result_o.speed_mmps)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wheel encoder speed testbench
// Drives encoder samples into the speed estimator and checks every result
// transaction against a cycle-free speed estimate or a hand-picked table row.
// ----------------------------------------------------------------------------
// The run starts with a short table of hand-picked samples: first samples,
// stale and repeated timestamps, count wrap, zero motion and saturation in
// both directions. It then walks through several register settings, from
// typical wheels to the extremes (zero direction, zero radius, zero pulses
// per revolution, full-scale values). Each setting is followed by random
// samples that are mostly well-formed, with stale timestamps and noise mixed
// in. The last setting pushes the timestamps to the top of their range.
// Both channel sides idle at random, apart from one phase with no idling.
// ----------------------------------------------------------------------------

module tb;
  import wes_pkg::*;

  // Sample outcomes as reported in sample_status.
  localparam logic Accepted = 1'b0;
  localparam logic Rejected = 1'b1;

  // Whether a table row carries its own expected status and speed, or the
  // expectation comes from the speed estimate.
  localparam logic FromTable = 1'b1;
  localparam logic FromModel = 1'b0;

  // Register indexes that the block does not implement.
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  localparam speed_t SpeedZero   = '0;
  localparam speed_t SpeedSatPos = speed_t'(SpeedMax);
  localparam speed_t SpeedSatNeg = -speed_t'(SpeedMax);

  localparam int NumDirected   = 20;
  localparam int NumPhases     = 6;
  localparam int ItemsPerPhase = 215;
  localparam int IdlePct       = 37;
  // Long enough for one more full calculation.
  localparam int DrainCycles   = 120;

  typedef struct packed {
    logic   status;
    logic   wheel;
    count_t count;
    time_t  stamp;
    speed_t speed;
  } speed_record_t;

  typedef struct packed {
    logic        wheel;
    logic [31:0] count;
    logic [63:0] stamp;
    logic        mode;
    logic        status;
    speed_t      speed;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  wes_sample_if sample_if ();
  wes_result_if result_if ();

  wheel_encoder_speed #(
    .NUM_WHEELS(2)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .sample_i  (sample_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Testbench copy of the registers and of the per-wheel baseline.
  logic [DirW-1:0]    dir_cfg    [2];
  logic [RadiusW-1:0] radius_cfg [2];
  logic [PprW-1:0]    ppr_cfg    [2];
  logic [31:0]        wheel_count[2];
  logic [63:0]        wheel_stamp[2];
  logic               wheel_based[2];

  speed_record_t predicted_speeds[$];
  sample_row_t   directed_rows[NumDirected];

  int wrong_fields   = 0;
  int samples_sent   = 0;
  int stale_samples  = 0;
  int saturated      = 0;
  int send_idle_pct  = IdlePct;
  int recv_idle_pct  = IdlePct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Speed estimate for one sample. It also moves the wheel baseline forward
  // when the sample is accepted, exactly as the block does.
  function automatic speed_record_t estimate_speed(input logic w, input logic [31:0] c,
                                                   input logic [63:0] t);
    speed_record_t r;
    logic [31:0]  diff;
    logic [31:0]  mag;
    logic         neg;
    logic [63:0]  dt;
    logic [127:0] prod;
    logic [63:0]  q;
    r.status = Accepted;
    r.wheel  = w;
    r.count  = c;
    r.stamp  = t;
    r.speed  = SpeedZero;
    if (wheel_based[w] && t <= wheel_stamp[w]) begin
      r.status = Rejected;
    end else begin
      if (wheel_based[w]) begin
        diff = c - wheel_count[w];
        neg  = diff[31];
        // The negation leaves the most negative delta at 2^31, as wanted.
        mag  = neg ? -diff : diff;
        dt   = t - wheel_stamp[w];
        if (dir_cfg[w] != '0 && ppr_cfg[w] != '0) begin
          prod = mag;
          prod = prod * radius_cfg[w];
          prod = prod * SpeedK;
          q    = prod[ScaleShift +: 64];
          q    = q / ppr_cfg[w];
          q    = q / dt;
          if (q > SpeedMax) q = SpeedMax;
          // Both negative direction patterns flip the sign.
          if (dir_cfg[w][1]) neg = ~neg;
          r.speed = neg ? -speed_t'(q) : speed_t'(q);
        end
      end
      wheel_count[w] = c;
      wheel_stamp[w] = t;
      wheel_based[w] = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    wrong_fields++;
    $display("%t ERROR %s", $realtime, what);
  endtask

  // Called at a falling edge; returns at the falling edge after the
  // transaction, with valid still high so a following sample can go out
  // back to back.
  task automatic send_sample(input logic w, input logic [31:0] c, input logic [63:0] t,
                             input logic mode, input logic lit_status,
                             input speed_t lit_speed);
    speed_record_t exp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(negedge clk);
    end
    sample_if.valid          <= 1'b1;
    sample_if.wheel_select   <= w;
    sample_if.raw_count      <= c;
    sample_if.sample_time_us <= t;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    exp = estimate_speed(w, c, t);
    if (mode == FromTable) begin
      exp.status = lit_status;
      exp.speed  = lit_speed;
    end
    samples_sent++;
    if (exp.status == Rejected) stale_samples++;
    if (exp.speed == SpeedSatPos || exp.speed == SpeedSatNeg) saturated++;
    predicted_speeds.push_back(exp);
    @(negedge clk);
  endtask

  // Random sample: mostly a plausible next reading of the wheel, some stale
  // timestamps and some noise with arbitrary counts and time steps.
  task automatic send_random_sample();
    logic        w;
    logic [31:0] c;
    logic [31:0] delta;
    logic [63:0] dt;
    logic [63:0] t;
    int          back;
    int          kind;
    w    = $urandom_range(0, 1);
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      case ($urandom_range(0, 3))
        0: delta = $urandom_range(0, 40) - 20;
        1: delta = $urandom_range(0, 4000) - 2000;
        2: delta = $urandom_range(0, 262144) - 131072;
        default: delta = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: dt = $urandom_range(1, 16);
        1: dt = $urandom_range(100, 20000);
        2: dt = $urandom_range(1, 1 << 20);
        default: dt = $urandom_range(1, 32'hFFFF_FFFF);
      endcase
      c = wheel_count[w] + delta;
      t = wheel_stamp[w] + dt;
    end else if (kind < 85) begin
      back = $urandom_range(0, 1000);
      c    = $urandom;
      t    = (wheel_stamp[w] >= back) ? wheel_stamp[w] - back : 64'd0;
    end else begin
      c  = $urandom;
      dt = $urandom;
      t  = wheel_stamp[w] + dt;
    end
    send_sample(w, c, t, FromModel, Accepted, SpeedZero);
  endtask

  // Lower valid and wait until every expected result has come back.
  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    @(negedge clk);
    while (predicted_speeds.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      RegDirW0:    dir_cfg[0]    = data[DirW-1:0];
      RegDirW1:    dir_cfg[1]    = data[DirW-1:0];
      RegRadiusW0: radius_cfg[0] = data[RadiusW-1:0];
      RegRadiusW1: radius_cfg[1] = data[RadiusW-1:0];
      RegPprW0:    ppr_cfg[0]    = data[PprW-1:0];
      RegPprW1:    ppr_cfg[1]    = data[PprW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all six registers. The bits above a narrow register's width are
  // filled at random, since the block has to drop them.
  task automatic set_config(input logic [1:0] d0, input logic [1:0] d1,
                            input logic [19:0] r0, input logic [19:0] r1,
                            input logic [15:0] p0, input logic [15:0] p1);
    logic [CfgDataW-1:0] pad;
    pad = $urandom;
    write_reg(RegDirW0, {pad[19:2], d0});
    pad = $urandom;
    write_reg(RegDirW1, {pad[19:2], d1});
    write_reg(RegRadiusW0, r0);
    write_reg(RegRadiusW1, r1);
    pad = $urandom;
    write_reg(RegPprW0, {pad[19:16], p0});
    pad = $urandom;
    write_reg(RegPprW1, {pad[19:16], p1});
    // Writes to the unused indexes must change nothing.
    write_reg(RegSpare6, $urandom);
    write_reg(RegSpare7, $urandom);
  endtask

  // Consumer side: ready is redrawn at every falling edge.
  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    speed_record_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (predicted_speeds.size() == 0) begin
        report_mismatch("result transaction with no sample waiting for it");
      end else begin
        want = predicted_speeds.pop_front();
        if (result_if.sample_status !== want.status)
          report_mismatch($sformatf("sample_status %b, wanted %b (wheel %0d, t %0d)",
                                    result_if.sample_status, want.status, want.wheel,
                                    want.stamp));
        if (result_if.wheel_echo !== want.wheel)
          report_mismatch($sformatf("wheel_echo %b, wanted %b", result_if.wheel_echo,
                                    want.wheel));
        if (result_if.count_echo !== want.count)
          report_mismatch($sformatf("count_echo %h, wanted %h", result_if.count_echo,
                                    want.count));
        if (result_if.time_echo_us !== want.stamp)
          report_mismatch($sformatf("time_echo_us %h, wanted %h", result_if.time_echo_us,
                                    want.stamp));
        if (result_if.speed_mmps !== want.speed)
          report_mismatch($sformatf("speed_mmps %0d, wanted %0d (wheel %0d, t %0d)",
                                    result_if.speed_mmps, want.speed, want.wheel,
                                    want.stamp));
      end
    end
  end

  initial begin
    logic [63:0] jump;
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_idx                  = '0;
    cfg_data                 = '0;
    sample_if.valid          = 1'b0;
    sample_if.wheel_select   = 1'b0;
    sample_if.raw_count      = '0;
    sample_if.sample_time_us = '0;
    result_if.ready          = 1'b0;
    for (int w = 0; w < 2; w++) begin
      dir_cfg[w]     = DirReset;
      radius_cfg[w]  = RadiusReset;
      ppr_cfg[w]     = PprReset;
      wheel_count[w] = '0;
      wheel_stamp[w] = '0;
      wheel_based[w] = 1'b0;
    end

    // Hand-picked samples under the reset settings (32.5 mm wheel, 1320
    // counts per turn). Rows with an obvious answer carry it here.
    directed_rows = '{
      // First sample of wheel 0 at time zero only sets the baseline.
      {1'b0, 32'h0000_0000, 64'd0,        FromTable, Accepted, SpeedZero},
      // Same timestamp again is stale.
      {1'b0, 32'h0000_1234, 64'd0,        FromTable, Rejected, SpeedZero},
      // One full turn in one second.
      {1'b0, 32'h0000_0528, 64'd1000000,  FromModel, Accepted, SpeedZero},
      {1'b0, 32'h0000_0528, 64'd2000000,  FromTable, Accepted, SpeedZero},
      // One full turn backwards.
      {1'b0, 32'h0000_0000, 64'd3000000,  FromModel, Accepted, SpeedZero},
      {1'b0, 32'hFFFF_FFFF, 64'd2999999,  FromTable, Rejected, SpeedZero},
      {1'b0, 32'hFFFF_FFFF, 64'd3000001,  FromModel, Accepted, SpeedZero},
      // Wheel 1 starts at the most negative count.
      {1'b1, 32'h8000_0000, 64'd5,        FromTable, Accepted, SpeedZero},
      // A delta of exactly -2^31 in one microsecond saturates low.
      {1'b1, 32'h0000_0000, 64'd6,        FromTable, Accepted, SpeedSatNeg},
      {1'b1, 32'h7FFF_FFFF, 64'd7,        FromTable, Accepted, SpeedSatPos},
      // The count wraps from the top to the bottom: a delta of +1.
      {1'b1, 32'h8000_0000, 64'd8,        FromModel, Accepted, SpeedZero},
      {1'b1, 32'h8000_0001, 64'd7,        FromTable, Rejected, SpeedZero},
      {1'b1, 32'h8000_0001, 64'd8,        FromTable, Rejected, SpeedZero},
      {1'b1, 32'h8000_0000, 64'd9,        FromTable, Accepted, SpeedZero},
      {1'b1, 32'h8000_0040, 64'd1000009,  FromModel, Accepted, SpeedZero},
      // A time step beyond 32 bits.
      {1'b1, 32'h8000_0100, 64'h0000_0001_000F_4249, FromModel, Accepted, SpeedZero},
      {1'b0, 32'h0001_0000, 64'd3000101,  FromModel, Accepted, SpeedZero},
      {1'b0, 32'h7FFF_0000, 64'd3000102,  FromTable, Accepted, SpeedSatPos},
      {1'b0, 32'hFFFF_0000, 64'd3000103,  FromTable, Accepted, SpeedSatNeg},
      {1'b0, 32'hFFFF_0001, 64'd3000104,  FromModel, Accepted, SpeedZero}
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumDirected; i++) begin
      send_sample(directed_rows[i].wheel, directed_rows[i].count, directed_rows[i].stamp,
                  directed_rows[i].mode, directed_rows[i].status, directed_rows[i].speed);
    end
    wait_drained();

    for (int phase = 1; phase <= NumPhases; phase++) begin
      case (phase)
        1: set_config(2'b01, 2'b11, 20'd32500, 20'd50000, 16'd1320, 16'd2048);
        // Large radii, extreme pulse counts, -2 direction pattern on wheel 0.
        2: set_config(2'b10, 2'b01, 20'd1000000, 20'hFFFFF, 16'hFFFF, 16'd1);
        // Zero direction on wheel 0; zero radius and zero pulses on wheel 1.
        3: set_config(2'b00, 2'b11, 20'd1, 20'd0, 16'd1, 16'd0);
        // Zero pulses with a live direction, and the smallest nonzero wheel.
        4: set_config(2'b11, 2'b01, 20'd1, 20'd1, 16'd0, 16'hFFFF);
        default: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      // One phase runs with neither side idling.
      send_idle_pct = (phase == 5) ? 0 : IdlePct;
      recv_idle_pct = (phase == 5) ? 0 : IdlePct;
      if (phase == NumPhases) begin
        // Move both wheels into the upper half of the time range.
        for (int w = 0; w < 2; w++) begin
          jump     = {$urandom, $urandom};
          jump[63] = 1'b1;
          send_sample(w, $urandom, jump, FromModel, Accepted, SpeedZero);
        end
      end
      repeat (ItemsPerPhase) send_random_sample();
      if (phase == NumPhases) begin
        // The last possible timestamp, then once more as a stale sample.
        for (int w = 0; w < 2; w++) begin
          send_sample(w, $urandom, '1, FromModel, Accepted, SpeedZero);
          send_sample(w, $urandom, '1, FromModel, Accepted, SpeedZero);
        end
      end
      wait_drained();
    end

    // Any late or extra result transaction shows up as unexpected here.
    repeat (DrainCycles) @(negedge clk);

    $display("Checked %0d samples under %0d register settings.", samples_sent,
             NumPhases + 1);
    $display("Of these, %0d were stale and %0d hit speed saturation.", stale_samples,
             saturated);
    if (wrong_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout at several times the slowest expected run.
  initial begin
    #10000000;
    $display("Timeout waiting for the sample or result channel");
    $display("Mismatches found");
    $finish;
  end

endmodule
